FILE: hdl/mrb_pkg.sv
package mrb_pkg;

	localparam int RING_DEPTH = 1024;
	localparam int ADDR_W     = $clog2(RING_DEPTH);
	localparam int LEN_W      = 11;
	localparam int SMP_W      = 16;
	localparam int CNT_W      = 16;

	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(RING_DEPTH);

	typedef enum logic {
		REQ_ADD   = 1'b0,
		REQ_FETCH = 1'b1
	} req_kind_t;

	typedef enum logic {
		ALU_WRAP = 1'b0,
		ALU_SAT  = 1'b1
	} alu_op_t;

	typedef struct packed {
		req_kind_t        req_type;
		logic [SMP_W-1:0] sample_in;
		logic             run_first;
		logic             run_last;
	} req_t;

	typedef struct packed {
		logic [SMP_W-1:0] sample_out;
		logic [LEN_W-1:0] stored_count;
		logic [CNT_W-1:0] underrun_count;
		logic [CNT_W-1:0] overflow_count;
		logic             out_last;
	} rsp_t;

endpackage

FILE: hdl/mrb_if.sv
interface mrb_req_if;
	import mrb_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mrb_rsp_if;
	import mrb_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/mixing_ring_buffer_core.sv
// Audio mixing ring of unsigned 16-bit samples.
// req channel: one word per sample. Add words mix sample_in into the ring at
//   (read pointer + run offset) mod length, saturating; fetch words pop the
//   oldest stored sample (zero once the ring is empty). run_first/run_last
//   frame a run; an add run extends the stored count when it ends.
// rsp channel: exactly one word per req word, in order, with the fetched
//   sample, stored count, saturating underrun/overflow counters and out_last.
// cfg: cfg_we/cfg_wdata write the ring length (clamped to 1..1024) and empty
//   the ring; counters are kept. Write only while the block is idle.
// Timing: the accept cycle computes the slot and reads the ring; the next
//   cycle writes the mixed sum back and loads the response register. The
//   single shared adder serves both steps and the ring has one
//   read-modify-write in flight, so a new word is not taken until the last
//   one has written back; rsp valid comes from the register loaded in that step.
// Stall: the response register holds until taken. A new req word is taken
//   in the same cycle the pending response leaves, so a stalled receiver
//   stalls the req side only while its word is waiting.
// Reset: arst_n clears pointers, counts, counters and the length (1024).
//   Ring contents are not cleared; unwritten slots are never read as data.
module mixing_ring_buffer_core (
	input  logic                       clk,
	input  logic                       arst_n,
	mrb_req_if.sink                    req,
	mrb_rsp_if.source                  rsp,
	input  logic                       cfg_we,
	input  logic [mrb_pkg::LEN_W-1:0]  cfg_wdata
);
	import mrb_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t           state_q;
	logic             out_valid_q;
	rsp_t             rsp_q;
	req_t             item_q;
	logic [LEN_W-1:0] len_q;      // length in use, already clamped
	logic [LEN_W-1:0] stored_q;
	logic [LEN_W-1:0] start_q;    // stored count at run start
	logic [LEN_W-1:0] off_q;      // run offset, holds at len+1
	logic [LEN_W-1:0] k_q;        // offset of the word in flight
	logic [ADDR_W-1:0] rp_q;
	logic [ADDR_W-1:0] addr_q;    // slot of the word in flight
	logic [CNT_W-1:0] under_q;
	logic [CNT_W-1:0] over_q;

	logic             accept;
	logic [LEN_W-1:0] k_in;
	logic [LEN_W-1:0] len_in;
	alu_op_t          alu_op;
	logic [SMP_W-1:0] alu_a;
	logic [SMP_W-1:0] alu_b;
	logic [SMP_W-1:0] alu_y;
	logic [SMP_W-1:0] rd_data;
	logic [SMP_W-1:0] old_smp;
	logic             is_fetch;
	logic             in_range;
	logic             at_len;
	logic             have_data;
	logic             mem_we;
	logic [LEN_W-1:0] run_len;
	logic [LEN_W-1:0] stored_nx;
	logic [CNT_W-1:0] under_nx;
	logic [CNT_W-1:0] over_nx;
	logic [ADDR_W-1:0] rp_nx;

	assign req.ready = (state_q == ST_IDLE) && (!out_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = rsp_q;

	assign k_in = req.data.run_first ? '0 : off_q;

	// clamp written length into 1..RING_DEPTH
	always_comb begin
		if (cfg_wdata == '0) begin
			len_in = LEN_W'(1);
		end else if (cfg_wdata > LEN_MAX) begin
			len_in = LEN_MAX;
		end else begin
			len_in = cfg_wdata;
		end
	end

	// execute-cycle decode
	assign is_fetch  = (item_q.req_type == REQ_FETCH);
	assign in_range  = (k_q < len_q);
	assign at_len    = (k_q == len_q);
	assign have_data = (stored_q != '0);
	// slots past the stored count at run start mix against zero
	assign old_smp   = (k_q < start_q) ? rd_data : '0;
	assign mem_we    = (state_q == ST_EXEC) && !is_fetch && in_range;
	assign run_len   = in_range ? (k_q + LEN_W'(1)) : len_q;

	// shared adder: slot address on accept, then mix sum or pointer step
	always_comb begin
		if (state_q == ST_IDLE) begin
			alu_op = ALU_WRAP;
			alu_a  = SMP_W'(rp_q);
			alu_b  = (req.data.req_type == REQ_FETCH) ? '0 : SMP_W'(k_in);
		end else if (is_fetch) begin
			alu_op = ALU_WRAP;
			alu_a  = SMP_W'(rp_q);
			alu_b  = SMP_W'(1);
		end else begin
			alu_op = ALU_SAT;
			alu_a  = old_smp;
			alu_b  = item_q.sample_in;
		end
	end

	mrb_alu u_alu (
		.op      (alu_op),
		.a       (alu_a),
		.b       (alu_b),
		.modulus (len_q),
		.y       (alu_y)
	);

	mrb_ring u_ring (
		.clk   (clk),
		.re    (accept),
		.raddr (alu_y[ADDR_W-1:0]),
		.rdata (rd_data),
		.we    (mem_we),
		.waddr (addr_q),
		.wdata (alu_y)
	);

	always_comb begin
		stored_nx = stored_q;
		under_nx  = under_q;
		over_nx   = over_q;
		rp_nx     = rp_q;
		if (is_fetch) begin
			if (at_len && (under_q != '1)) begin
				under_nx = under_q + CNT_W'(1);
			end
			if (have_data) begin
				stored_nx = stored_q - LEN_W'(1);
				rp_nx     = alu_y[ADDR_W-1:0];
			end
		end else begin
			if (at_len && (over_q != '1)) begin
				over_nx = over_q + CNT_W'(1);
			end
			if (item_q.run_last && (run_len > stored_q)) begin
				stored_nx = run_len;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			rsp_q       <= '0;
			item_q      <= '0;
			len_q       <= LEN_MAX;
			stored_q    <= '0;
			start_q     <= '0;
			off_q       <= '0;
			k_q         <= '0;
			rp_q        <= '0;
			addr_q      <= '0;
			under_q     <= '0;
			over_q      <= '0;
		end else begin
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						item_q  <= req.data;
						k_q     <= k_in;
						addr_q  <= alu_y[ADDR_W-1:0];
						if (req.data.run_first) begin
							start_q <= stored_q;
						end
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					off_q    <= (k_q <= len_q) ? (k_q + LEN_W'(1)) : k_q;
					stored_q <= stored_nx;
					under_q  <= under_nx;
					over_q   <= over_nx;
					rp_q     <= rp_nx;
					rsp_q.sample_out     <= (is_fetch && have_data) ? rd_data : '0;
					rsp_q.stored_count   <= stored_nx;
					rsp_q.underrun_count <= under_nx;
					rsp_q.overflow_count <= over_nx;
					rsp_q.out_last       <= item_q.run_last;
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// length write empties the ring
			if (cfg_we) begin
				len_q    <= len_in;
				rp_q     <= '0;
				stored_q <= '0;
				start_q  <= '0;
				off_q    <= '0;
			end
		end
	end

	a_stored_le_len: assert property (@(posedge clk) disable iff (!arst_n)
		stored_q <= len_q)
		else $error("stored count above ring length");

	a_rp_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		LEN_W'(rp_q) < len_q)
		else $error("read pointer outside ring");

	a_exec_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EXEC |=> state_q == ST_IDLE && out_valid_q)
		else $error("execute cycle did not produce a response");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !out_valid_q || rsp.ready)
		else $error("word accepted while response register busy");

endmodule

FILE: hdl/mrb_alu.sv
module mrb_alu (
	input  mrb_pkg::alu_op_t           op,
	input  logic [mrb_pkg::SMP_W-1:0]  a,
	input  logic [mrb_pkg::SMP_W-1:0]  b,
	input  logic [mrb_pkg::LEN_W-1:0]  modulus,
	output logic [mrb_pkg::SMP_W-1:0]  y
);
	import mrb_pkg::*;

	logic [SMP_W:0] sum;
	logic [SMP_W:0] mod_ext;

	assign sum     = {1'b0, a} + {1'b0, b};
	assign mod_ext = (SMP_W+1)'(modulus);

	// wrap: operands below modulus, so one compare-subtract suffices
	always_comb begin
		case (op)
			ALU_WRAP: begin
				if (sum >= mod_ext) begin
					y = SMP_W'(sum - mod_ext);
				end else begin
					y = sum[SMP_W-1:0];
				end
			end
			ALU_SAT: begin
				y = sum[SMP_W] ? '1 : sum[SMP_W-1:0];
			end
			default: begin
				y = sum[SMP_W-1:0];
			end
		endcase
	end

endmodule

FILE: hdl/mrb_ring.sv
module mrb_ring (
	input  logic                        clk,
	input  logic                        re,
	input  logic [mrb_pkg::ADDR_W-1:0]  raddr,
	output logic [mrb_pkg::SMP_W-1:0]   rdata,
	input  logic                        we,
	input  logic [mrb_pkg::ADDR_W-1:0]  waddr,
	input  logic [mrb_pkg::SMP_W-1:0]   wdata
);
	import mrb_pkg::*;

	logic [SMP_W-1:0] mem [RING_DEPTH];
	logic [SMP_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
